// File: sv/kpsde_pkg.sv
// Shared constants and types for the two-digit keypad entry block.
package kpsde_pkg;

  localparam int unsigned ColumnsDefault = 3;
  localparam int unsigned RowsDefault    = 4;

  localparam int unsigned RowW     = 4;  // row readback bits on the port
  localparam int unsigned ColDrvW  = 3;  // column drive bits on the port
  localparam int unsigned ColIdxW  = 2;  // up to four columns
  localparam int unsigned RowIdxW  = 2;  // up to four rows
  localparam int unsigned KeyW     = 4;  // key number minus one
  localparam int unsigned DigitW   = 4;
  localparam int unsigned AddrW    = 2;
  localparam int unsigned FrameW   = 8;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [AddrW-1:0] AddrReset = 2'd3;

  // key numbers, one based
  localparam logic [KeyW:0] KeyLastDigit = 5'd9;
  localparam logic [KeyW:0] KeyLamp      = 5'd10;
  localparam logic [KeyW:0] KeyZero      = 5'd11;
  localparam logic [KeyW:0] KeySend      = 5'd12;

  typedef struct packed {
    logic               hit;  // exactly one row low
    logic [RowIdxW-1:0] row;
  } row_hit_t;

endpackage

// File: sv/keypad_scan_two_digit_entry.sv
// Keypad scanner with two-digit entry, lamp toggle and frame send.
// A sample's result is registered for the master; it can drain as the next is taken.
// Throughput: one row sample per cycle unless the result register is full and stalled.
// Reset: column 0, no key held, digits zero, lamp on, address 3, result register empty.
// The scan, key decode and digit update all resolve in the cycle of acceptance.
module keypad_scan_two_digit_entry #(
  parameter int unsigned COLUMNS = kpsde_pkg::ColumnsDefault,
  parameter int unsigned ROWS    = kpsde_pkg::RowsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kpsde_pkg::AddrW-1:0]       cfg_wdata_i,  // destination_address
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [kpsde_pkg::InDataW-1:0]     s_axis_tdata,  // [3:0] row_lines
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] column_drive, [3] frame_valid, [11:4] frame_byte, [12] lamp_level
  output logic [kpsde_pkg::OutDataW-1:0]    m_axis_tdata
);

  localparam logic [kpsde_pkg::RowW-1:0] RowMask =
    kpsde_pkg::RowW'((1 << ROWS) - 1);
  localparam logic [kpsde_pkg::ColIdxW:0] ColCount =
    (kpsde_pkg::ColIdxW + 1)'(COLUMNS);

  logic [kpsde_pkg::AddrW-1:0]   addr_q;
  logic [kpsde_pkg::ColIdxW-1:0] col_q, col_d, col_cur, col_nxt;
  logic                          held_q, held_d;
  logic [kpsde_pkg::RowW-1:0]    held_rows_q, held_rows_d;
  logic [kpsde_pkg::KeyW-1:0]    held_key_q, held_key_d;
  logic [kpsde_pkg::DigitW-1:0]  tens_q, tens_d, units_q, units_d;
  logic                          lamp_q, lamp_d;
  logic                          out_valid_q;
  logic [kpsde_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic [kpsde_pkg::RowW-1:0]    rows;
  kpsde_pkg::row_hit_t           hit;
  logic                          accept;
  logic [kpsde_pkg::KeyW:0]      key;
  logic                          frame_valid;
  logic [kpsde_pkg::FrameW-1:0]  frame_byte;
  logic [kpsde_pkg::ColDrvW-1:0] col_drive;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign rows          = s_axis_tdata[kpsde_pkg::RowW-1:0] & RowMask;

  kpsde_row_decode #(
    .ROWS (ROWS)
  ) u_row_decode (
    .rows_i (rows),
    .hit_o  (hit)
  );

  always_comb begin
    col_cur = ({1'b0, col_q} >= ColCount) ? '0 : col_q;
    col_nxt = (({1'b0, col_cur} + 1'b1) >= ColCount) ? '0 : col_cur + 1'b1;
  end

  always_comb begin
    col_d       = col_cur;
    held_d      = held_q;
    held_rows_d = held_rows_q;
    held_key_d  = held_key_q;
    tens_d      = tens_q;
    units_d     = units_q;
    lamp_d      = lamp_q;
    frame_valid = 1'b0;
    frame_byte  = '0;
    key         = {1'b0, held_key_q} + 1'b1;
    if (!held_q) begin
      if (hit.hit) begin
        held_d      = 1'b1;
        held_rows_d = rows;
        held_key_d  = kpsde_pkg::KeyW'(int'(hit.row) * COLUMNS + int'(col_cur));
      end else begin
        col_d = col_nxt;
      end
    end else if (rows != (held_rows_q & RowMask)) begin
      // the held key acts on release (any change of the pattern)
      if (key == kpsde_pkg::KeySend) begin
        frame_valid = 1'b1;
        frame_byte  = {addr_q, 6'b0}
                    | (kpsde_pkg::FrameW'(tens_q) * 8'd10 + kpsde_pkg::FrameW'(units_q));
        tens_d      = '0;
        units_d     = '0;
      end else if (key == kpsde_pkg::KeyLamp) begin
        lamp_d = !lamp_q;
      end else if (key <= kpsde_pkg::KeyZero) begin
        tens_d  = units_q;
        units_d = (key == kpsde_pkg::KeyZero) ? '0 : kpsde_pkg::DigitW'(key);
      end
      held_d      = 1'b0;
      held_rows_d = '1;
      col_d       = col_nxt;
    end
  end

  always_comb begin
    col_drive  = ~kpsde_pkg::ColDrvW'(4'b0001 << col_d);
    out_data_d = '0;
    out_data_d[2:0]  = col_drive;
    out_data_d[3]    = frame_valid;
    out_data_d[11:4] = frame_byte;
    out_data_d[12]   = lamp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= kpsde_pkg::AddrReset;
    end else if (cfg_we_i) begin
      addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      held_q      <= 1'b0;
      held_rows_q <= '1;
      held_key_q  <= '0;
      tens_q      <= '0;
      units_q     <= '0;
      lamp_q      <= 1'b1;
    end else if (accept) begin
      col_q       <= col_d;
      held_q      <= held_d;
      held_rows_q <= held_rows_d;
      held_key_q  <= held_key_d;
      tens_q      <= tens_d;
      units_q     <= units_d;
      lamp_q      <= lamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  // a held key always has exactly one low row captured
  a_held_one_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> ($countones(~held_rows_q & RowMask) == 1))
    else $error("held key without a single low row");

  // scan column never leaves the configured range
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < ColCount))
    else $error("column index out of range");

  // a sent frame clears both digits
  a_send_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_valid) |=> (tens_q == '0 && units_q == '0))
    else $error("digits not cleared after send");

  // an unchanged pattern keeps the scan on the held column
  a_hold_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && held_q && rows == held_rows_q) |=> ($stable(col_q) && held_q))
    else $error("scan moved while key held");

  // digits only ever hold decimal values
  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tens_q <= 4'd9 && units_q <= 4'd9))
    else $error("digit register out of decimal range");
`endif

endmodule

// File: sv/kpsde_row_decode.sv
// Finds the single low row in the masked row readback.
module kpsde_row_decode #(
  parameter int unsigned ROWS = kpsde_pkg::RowsDefault
) (
  input  logic [kpsde_pkg::RowW-1:0] rows_i,
  output kpsde_pkg::row_hit_t        hit_o
);

  always_comb begin
    logic                          found;
    logic                          multi;
    logic [kpsde_pkg::RowIdxW-1:0] idx;
    found = 1'b0;
    multi = 1'b0;
    idx   = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (!rows_i[r]) begin
        if (found) begin
          multi = 1'b1;
        end
        found = 1'b1;
        idx   = kpsde_pkg::RowIdxW'(r);
      end
    end
    hit_o.hit = found && !multi;
    hit_o.row = idx;
  end

endmodule
